// ----- rtl/skwn_pkg.sv -----
// Package for the top-four skin weight normalizer: widths, constants,
// status codes, controller states and the controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps

package skwn_pkg;

    localparam int MAX_BONES_DEF  = 256;
    localparam int SLOTS_DEF      = 4;

    localparam int BONE_W         = 8;
    localparam int WEIGHT_W       = 16;
    localparam int SLOT_WEIGHT_W  = 15;
    localparam int NORM_W         = 16;
    localparam int STATUS_W       = 2;
    localparam int OUT_SLOTS      = 4;

    // 1.0 on the output scale
    localparam int ONE_OUT        = 32768;

    // three quotients, one quotient bit per divider step
    localparam int NUM_DIV        = 3;
    localparam int DIV_SEL_W      = $clog2(NUM_DIV);
    localparam int DIV_STEPS      = NORM_W;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_SUM = 2'd1,
        STATUS_NEGATIVE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 load_item;
        logic                 sum_start;
        logic                 div_load;
        logic                 div_step;
        logic                 div_store;
        logic [DIV_SEL_W-1:0] div_sel;
        logic                 clear;
    } skwn_cmd_t;

    typedef struct packed {
        logic error;
    } skwn_stat_t;

endpackage

// ----- rtl/skwn_ctrl.sv -----
// Controller state machine of the skin weight normalizer.
// Sequences item load, sum, three iterative divisions and the result strobe.
// Depends on skwn_pkg.
`timescale 1ns / 1ps

module skwn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last_influence,
    input  skwn_pkg::skwn_stat_t stat,
    output skwn_pkg::skwn_cmd_t cmd,
    output logic                busy,
    output logic                done
);
    import skwn_pkg::*;

    state_t                state_reg, state_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_SEL_W-1:0]  sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last_influence)
                    state_next = ST_SUM;
            end
            ST_SUM:
                state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:
            begin
                if (stat.error)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE:
            begin
                if (sel_reg == DIV_SEL_W'(NUM_DIV - 1))
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV_LOAD;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // step and quotient counters
    always_comb
    begin
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        case (state_reg)
            ST_SUM:       sel_next = '0;
            ST_DIV_LOAD:  cnt_next = '0;
            ST_DIV_STEP:  cnt_next = cnt_reg + STEP_W'(1);
            ST_DIV_STORE: sel_next = sel_reg + DIV_SEL_W'(1);
            default:      ;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        busy          = (state_reg != ST_IDLE);
        done          = 1'b0;
        case (state_reg)
            ST_IDLE:      cmd.load_item = start;
            ST_SUM:       cmd.sum_start = 1'b1;
            ST_DIV_LOAD:  cmd.div_load  = 1'b1;
            ST_DIV_STEP:  cmd.div_step  = 1'b1;
            ST_DIV_STORE: cmd.div_store = 1'b1;
            ST_DONE:
            begin
                cmd.clear = 1'b1;
                done      = 1'b1;
            end
            default:      ;
        endcase
    end

endmodule

// ----- rtl/skwn_dp.sv -----
// Datapath of the skin weight normalizer: influence slots, weight sum,
// a restoring divider with one quotient bit per cycle, and result fields.
// Depends on skwn_pkg.
`timescale 1ns / 1ps

module skwn_dp #(
    parameter int MAX_BONES = skwn_pkg::MAX_BONES_DEF,
    parameter int SLOTS     = skwn_pkg::SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  skwn_pkg::skwn_cmd_t                 cmd,
    output skwn_pkg::skwn_stat_t                stat,
    input  logic                                influence_present,
    input  logic [skwn_pkg::BONE_W-1:0]         bone_index,
    input  logic signed [skwn_pkg::WEIGHT_W-1:0] influence_weight,
    output logic [skwn_pkg::BONE_W-1:0]         bone_id_0,
    output logic [skwn_pkg::BONE_W-1:0]         bone_id_1,
    output logic [skwn_pkg::BONE_W-1:0]         bone_id_2,
    output logic [skwn_pkg::BONE_W-1:0]         bone_id_3,
    output logic [skwn_pkg::NORM_W-1:0]         norm_weight_0,
    output logic [skwn_pkg::NORM_W-1:0]         norm_weight_1,
    output logic [skwn_pkg::NORM_W-1:0]         norm_weight_2,
    output logic [skwn_pkg::NORM_W-1:0]         norm_weight_3,
    output logic [skwn_pkg::STATUS_W-1:0]       status
);
    import skwn_pkg::*;

    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W   = SLOT_WEIGHT_W + $clog2(SLOTS);
    localparam int REM_W   = SUM_W + 1;

    logic [BONE_W-1:0]        slot_bone_reg [SLOTS];
    logic [SLOT_WEIGHT_W-1:0] slot_w_reg    [SLOTS];
    logic                     neg_seen_reg;

    logic [BONE_W-1:0]        pad_bone [OUT_SLOTS];
    logic [SLOT_WEIGHT_W-1:0] pad_w    [OUT_SLOTS];

    logic [SLOT_IW-1:0]       pick;
    logic                     is_negative;
    logic                     in_range;
    logic [SLOT_WEIGHT_W-1:0] new_w;
    logic                     take;

    logic [SUM_W-1:0]         sum_comb;
    status_t                  status_comb;

    logic [SUM_W-1:0]         sum_reg;
    status_t                  status_reg;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [NORM_W-1:0]        quo_reg, quo_next;
    logic [NORM_W-1:0]        q_reg [NUM_DIV];
    logic [REM_W-1:0]         rem_diff;
    logic                     rem_ge;
    logic [REM_W-1:0]         rem_kept;

    // pad the slot file out to the four result positions
    for (genvar k = 0; k < OUT_SLOTS; k++)
    begin : g_pad
        if (k < SLOTS)
        begin : g_used
            assign pad_bone[k] = slot_bone_reg[k];
            assign pad_w[k]    = slot_w_reg[k];
        end
        else
        begin : g_unused
            assign pad_bone[k] = '0;
            assign pad_w[k]    = '0;
        end
    end

    // lowest-numbered smallest slot
    always_comb
    begin
        pick = '0;
        for (int k = 1; k < SLOTS; k++)
        begin
            if (slot_w_reg[k] < slot_w_reg[pick])
                pick = SLOT_IW'(k);
        end
    end

    assign is_negative = influence_weight[WEIGHT_W-1];
    assign in_range    = (32'(bone_index) < 32'(MAX_BONES));
    assign new_w       = influence_weight[SLOT_WEIGHT_W-1:0];
    assign take        = cmd.load_item && influence_present && !is_negative
                         && in_range && (new_w > slot_w_reg[pick]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_bone_reg[k] <= '0;
                slot_w_reg[k]    <= '0;
            end
            neg_seen_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_bone_reg[k] <= '0;
                slot_w_reg[k]    <= '0;
            end
            neg_seen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item && influence_present && is_negative)
                neg_seen_reg <= 1'b1;
            if (take)
            begin
                slot_bone_reg[pick] <= bone_index;
                slot_w_reg[pick]    <= new_w;
            end
        end
    end

    always_comb
    begin
        sum_comb = '0;
        for (int k = 0; k < SLOTS; k++)
            sum_comb = sum_comb + SUM_W'(slot_w_reg[k]);
    end

    always_comb
    begin
        if (neg_seen_reg)
            status_comb = STATUS_NEGATIVE;
        else if (sum_comb == '0)
            status_comb = STATUS_ZERO_SUM;
        else
            status_comb = STATUS_OK;
    end

    // restoring division of w * 2^15 by the sum; w <= sum, so start at w
    assign rem_ge   = (rem_reg >= REM_W'(sum_reg));
    assign rem_diff = rem_reg - REM_W'(sum_reg);
    assign rem_kept = rem_ge ? rem_diff : rem_reg;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_load)
        begin
            rem_next = REM_W'(pad_w[cmd.div_sel]);
            quo_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = {rem_kept[REM_W-2:0], 1'b0};
            quo_next = {quo_reg[NORM_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.sum_start)
        begin
            sum_reg    <= sum_comb;
            status_reg <= status_comb;
            for (int k = 0; k < NUM_DIV; k++)
                q_reg[k] <= '0;
        end
        else if (cmd.div_store)
        begin
            q_reg[cmd.div_sel] <= quo_reg;
        end
    end

    assign stat.error    = (status_reg != STATUS_OK);

    assign bone_id_0     = pad_bone[0];
    assign bone_id_1     = pad_bone[1];
    assign bone_id_2     = pad_bone[2];
    assign bone_id_3     = pad_bone[3];
    assign norm_weight_0 = q_reg[0];
    assign norm_weight_1 = q_reg[1];
    assign norm_weight_2 = q_reg[2];
    assign norm_weight_3 = (status_reg == STATUS_OK)
                           ? NORM_W'(18'(ONE_OUT) - 18'(q_reg[0]) - 18'(q_reg[1])
                                     - 18'(q_reg[2]))
                           : '0;
    assign status        = status_reg;

endmodule

// ----- rtl/skin_weight_top4_normalizer_core.sv -----
// Top level of the top-four skin weight normalizer.
// Joins the controller (skwn_ctrl) and the datapath (skwn_dp); uses skwn_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive the item fields and raise start; the item is taken
//   at a rising edge where start is high and busy is low. An item without
//   last_influence is absorbed at that edge and busy stays low, so the
//   next item may follow in the next cycle.
//   An item with last_influence raises busy while the block sums the slots
//   and runs three quotients through one restoring divider, one quotient bit
//   per cycle. From that accept edge the controller runs the sum state,
//   then load, 16 divider steps and store for each of three quotients, then
//   the result state with done; when status reports an error the divisions
//   are skipped and done follows the first load state.
//   Result channel: done is high for exactly one cycle, with bone_id_*,
//   norm_weight_* and status valid in that cycle. The receiver cannot stall;
//   it must capture the item on that edge. Slots clear as done ends.
//   Reset (rst_n low, asynchronous) empties all slots, drops the negative
//   weight flag and returns the controller to idle.
module skin_weight_top4_normalizer_core #(
    parameter int MAX_BONES = skwn_pkg::MAX_BONES_DEF,
    parameter int SLOTS     = skwn_pkg::SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 influence_present,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_index,
    input  logic signed [skwn_pkg::WEIGHT_W-1:0] influence_weight,
    input  logic                                 last_influence,
    output logic                                 done,
    output logic [skwn_pkg::BONE_W-1:0]          bone_id_0,
    output logic [skwn_pkg::BONE_W-1:0]          bone_id_1,
    output logic [skwn_pkg::BONE_W-1:0]          bone_id_2,
    output logic [skwn_pkg::BONE_W-1:0]          bone_id_3,
    output logic [skwn_pkg::NORM_W-1:0]          norm_weight_0,
    output logic [skwn_pkg::NORM_W-1:0]          norm_weight_1,
    output logic [skwn_pkg::NORM_W-1:0]          norm_weight_2,
    output logic [skwn_pkg::NORM_W-1:0]          norm_weight_3,
    output logic [skwn_pkg::STATUS_W-1:0]        status
);
    import skwn_pkg::*;

    skwn_cmd_t  cmd;
    skwn_stat_t stat;

    // sequence: accept item, sum, divide three times, strobe result
    skwn_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .last_influence (last_influence),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy),
        .done           (done)
    );

    // hold the slots and compute the normalized weights
    skwn_dp #(
        .MAX_BONES (MAX_BONES),
        .SLOTS     (SLOTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .influence_present (influence_present),
        .bone_index        (bone_index),
        .influence_weight  (influence_weight),
        .bone_id_0         (bone_id_0),
        .bone_id_1         (bone_id_1),
        .bone_id_2         (bone_id_2),
        .bone_id_3         (bone_id_3),
        .norm_weight_0     (norm_weight_0),
        .norm_weight_1     (norm_weight_1),
        .norm_weight_2     (norm_weight_2),
        .norm_weight_3     (norm_weight_3),
        .status            (status)
    );

endmodule

// ----- test/skwn_checker.sv -----
// Scoreboard for the top-four skin weight normalizer: tracks the four slots,
// predicts each vertex result and compares it with what the block emits.
// Depends on skwn_pkg for widths, the output scale and the status codes.
`timescale 1ns / 1ps

module skwn_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 influence_present,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_index,
    input  logic signed [skwn_pkg::WEIGHT_W-1:0] influence_weight,
    input  logic                                 last_influence,
    input  logic                                 done,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_id_0,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_id_1,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_id_2,
    input  logic [skwn_pkg::BONE_W-1:0]          bone_id_3,
    input  logic [skwn_pkg::NORM_W-1:0]          norm_weight_0,
    input  logic [skwn_pkg::NORM_W-1:0]          norm_weight_1,
    input  logic [skwn_pkg::NORM_W-1:0]          norm_weight_2,
    input  logic [skwn_pkg::NORM_W-1:0]          norm_weight_3,
    input  logic [skwn_pkg::STATUS_W-1:0]        status,
    output int                                   fail_count,
    output int                                   pending
);
    import skwn_pkg::*;

    // awaited results; one vertex at most is in flight, so a few entries do
    localparam int AWAIT_PTR_W = 3;
    localparam int AWAIT_DEPTH = 1 << AWAIT_PTR_W;
    localparam int PICK_W      = $clog2(OUT_SLOTS);

    typedef struct packed {
        logic [OUT_SLOTS-1:0][BONE_W-1:0] bone;
        logic [OUT_SLOTS-1:0][NORM_W-1:0] weight;
        status_t                          code;
    } blend_t;

    blend_t                   awaited_blends [AWAIT_DEPTH];
    logic [AWAIT_PTR_W-1:0]   await_head;
    logic [AWAIT_PTR_W-1:0]   await_tail;
    int                       await_count;
    logic [BONE_W-1:0]        slot_bone   [OUT_SLOTS];
    logic [SLOT_WEIGHT_W-1:0] slot_weight [OUT_SLOTS];
    logic                     negative_seen;
    int                       mismatches;

    assign fail_count = mismatches;

    always @(posedge clk or negedge rst_n)
    begin : track_slots
        blend_t            got;
        blend_t            want;
        logic [PICK_W-1:0] pick;
        int unsigned       weight_sum;
        int unsigned       used;
        int unsigned       quotient;

        if (!rst_n)
        begin
            for (int k = 0; k < OUT_SLOTS; k++)
            begin
                slot_bone[k]   = '0;
                slot_weight[k] = '0;
            end
            negative_seen = 1'b0;
            await_head    = '0;
            await_tail    = '0;
            await_count   = 0;
            mismatches    = 0;
            pending <= 0;
        end
        else
        begin
            // compare first: a result always belongs to an earlier item
            if (done)
            begin
                if (await_count == 0)
                begin
                    $display("%0t: result with nothing awaited", $time);
                    mismatches++;
                end
                else
                begin
                    want        = awaited_blends[await_head];
                    await_head  = await_head + AWAIT_PTR_W'(1);
                    await_count--;
                    got.bone   = {bone_id_3, bone_id_2, bone_id_1, bone_id_0};
                    got.weight = {norm_weight_3, norm_weight_2, norm_weight_1,
                                  norm_weight_0};
                    got.code   = status_t'(status);
                    for (int k = 0; k < OUT_SLOTS; k++)
                    begin
                        if (got.bone[k] !== want.bone[k])
                        begin
                            $display("%0t: bone_id_%0d expected %0d, got %0d",
                                     $time, k, want.bone[k], got.bone[k]);
                            mismatches++;
                        end
                        if (got.weight[k] !== want.weight[k])
                        begin
                            $display("%0t: norm_weight_%0d expected %0d, got %0d",
                                     $time, k, want.weight[k], got.weight[k]);
                            mismatches++;
                        end
                    end
                    if (got.code !== want.code)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.code, got.code);
                        mismatches++;
                    end
                end
            end

            if (start && !busy)
            begin
                if (influence_present)
                begin
                    if (influence_weight[WEIGHT_W-1])
                        negative_seen = 1'b1;
                    else if (int'(bone_index) < MAX_BONES_DEF)
                    begin
                        // lowest-numbered smallest slot, replaced on strictly greater
                        pick = '0;
                        for (int k = 1; k < OUT_SLOTS; k++)
                            if (slot_weight[k] < slot_weight[pick])
                                pick = PICK_W'(k);
                        if (influence_weight[SLOT_WEIGHT_W-1:0] > slot_weight[pick])
                        begin
                            slot_weight[pick] = influence_weight[SLOT_WEIGHT_W-1:0];
                            slot_bone[pick]   = bone_index;
                        end
                    end
                end

                if (last_influence)
                begin
                    weight_sum = 0;
                    for (int k = 0; k < OUT_SLOTS; k++)
                        weight_sum += slot_weight[k];
                    if (negative_seen)
                        want.code = STATUS_NEGATIVE;
                    else if (weight_sum == 0)
                        want.code = STATUS_ZERO_SUM;
                    else
                        want.code = STATUS_OK;

                    used = 0;
                    for (int k = 0; k < OUT_SLOTS; k++)
                    begin
                        want.bone[k]   = slot_bone[k];
                        want.weight[k] = '0;
                    end
                    for (int k = 0; k < OUT_SLOTS - 1; k++)
                    begin
                        quotient = 0;
                        if (want.code == STATUS_OK)
                            quotient = (int'(slot_weight[k]) * ONE_OUT) / weight_sum;
                        want.weight[k] = quotient[NORM_W-1:0];
                        used += quotient;
                    end
                    if (want.code == STATUS_OK)
                        want.weight[OUT_SLOTS-1] = 16'(ONE_OUT - used);

                    if (await_count == AWAIT_DEPTH)
                    begin
                        $display("%0t: too many results awaited, expected at most %0d, got %0d",
                                 $time, AWAIT_DEPTH, await_count + 1);
                        mismatches++;
                    end
                    else
                    begin
                        awaited_blends[await_tail] = want;
                        await_tail  = await_tail + AWAIT_PTR_W'(1);
                        await_count++;
                    end

                    for (int k = 0; k < OUT_SLOTS; k++)
                    begin
                        slot_bone[k]   = '0;
                        slot_weight[k] = '0;
                    end
                    negative_seen = 1'b0;
                end
            end
            pending <= await_count;
        end
    end

endmodule

// ----- test/skin_weight_top4_normalizer_core_test.sv -----
// Regression bench for skin_weight_top4_normalizer_core: directed vertices,
// then random vertices under three idling profiles. Uses skwn_pkg and skwn_checker.
`timescale 1ns / 1ps

module skin_weight_top4_normalizer_core_test;

    import skwn_pkg::*;

    // cycles with neither an accepted item nor a result before giving up;
    // the worst quiet stretch is one vertex's sum and divisions plus a sender gap
    localparam int WATCHDOG_LIMIT = 2000;
    // drain time after the last result, longer than one vertex's sum and divisions
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 615;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        influence_present;
    logic [BONE_W-1:0]           bone_index;
    logic signed [WEIGHT_W-1:0]  influence_weight;
    logic                        last_influence;
    logic                        done;
    logic [BONE_W-1:0]           bone_id_0;
    logic [BONE_W-1:0]           bone_id_1;
    logic [BONE_W-1:0]           bone_id_2;
    logic [BONE_W-1:0]           bone_id_3;
    logic [NORM_W-1:0]           norm_weight_0;
    logic [NORM_W-1:0]           norm_weight_1;
    logic [NORM_W-1:0]           norm_weight_2;
    logic [NORM_W-1:0]           norm_weight_3;
    logic [STATUS_W-1:0]         status;

    int fail_count;
    int pending;
    int idle_pct;
    int items_sent;
    int quiet_cycles;

    skin_weight_top4_normalizer_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .influence_present (influence_present),
        .bone_index        (bone_index),
        .influence_weight  (influence_weight),
        .last_influence    (last_influence),
        .done              (done),
        .bone_id_0         (bone_id_0),
        .bone_id_1         (bone_id_1),
        .bone_id_2         (bone_id_2),
        .bone_id_3         (bone_id_3),
        .norm_weight_0     (norm_weight_0),
        .norm_weight_1     (norm_weight_1),
        .norm_weight_2     (norm_weight_2),
        .norm_weight_3     (norm_weight_3),
        .status            (status)
    );

    skwn_checker scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .influence_present (influence_present),
        .bone_index        (bone_index),
        .influence_weight  (influence_weight),
        .last_influence    (last_influence),
        .done              (done),
        .bone_id_0         (bone_id_0),
        .bone_id_1         (bone_id_1),
        .bone_id_2         (bone_id_2),
        .bone_id_3         (bone_id_3),
        .norm_weight_0     (norm_weight_0),
        .norm_weight_1     (norm_weight_1),
        .norm_weight_2     (norm_weight_2),
        .norm_weight_3     (norm_weight_3),
        .status            (status),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: count cycles in which the block neither takes an item nor
    // emits a result; a hung controller trips this well before the end.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("skin_weight_top4_normalizer_core regression: fail");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the block takes it. Random idle cycles
    // go in front of the item; with no idle, start stays high back to back.
    task automatic send_item(input logic present, input logic [BONE_W-1:0] bone,
                             input logic signed [WEIGHT_W-1:0] weight,
                             input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start             <= 1'b1;
        influence_present <= present;
        bone_index        <= bone;
        influence_weight  <= weight;
        last_influence    <= last;
        @(posedge clk);
        // busy is sampled as it stood before this edge
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // One random vertex: a few influences and a closing item marked last.
    // Mostly well-formed; sprinkle in negative weights and empty markers.
    task automatic send_vertex();
        int                         count;
        int                         style;
        int                         roll;
        logic                       present;
        logic signed [WEIGHT_W-1:0] weight;

        count = $urandom_range(0, 6);
        style = $urandom_range(3);
        for (int k = 0; k <= count; k++)
        begin
            roll    = $urandom_range(99);
            present = 1'b1;
            case (style)
                0:       weight = WEIGHT_W'($urandom_range(0, 7));        // ties galore
                1:       weight = WEIGHT_W'($urandom_range(0, 255));
                default: weight = WEIGHT_W'($urandom_range(0, 32767));
            endcase
            if (roll < 5)
                weight = WEIGHT_W'(-int'($urandom_range(1, 32768)));
            else if (roll < 12)
                present = 1'b0;
            // the closing item is an empty marker half the time
            if (k == count && $urandom_range(1) == 0)
                present = 1'b0;
            send_item(present, BONE_W'($urandom_range(0, 255)), weight, k == count);
        end
    endtask

    initial
    begin
        start             = 1'b0;
        influence_present = 1'b0;
        bone_index        = '0;
        influence_weight  = '0;
        last_influence    = 1'b0;
        rst_n             = 1'b0;
        idle_pct          = 20;
        items_sent        = 0;
        quiet_cycles      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty vertex gives a zero sum
        send_item(1'b0, 8'd0, 16'sd0, 1'b1);
        // single full weight takes the whole output scale
        send_item(1'b1, 8'd0, 16'sd16384, 1'b1);
        // zero weight never enters; tie at the top is dropped; tiny one dropped
        send_item(1'b1, 8'd10, 16'sd0, 1'b0);
        send_item(1'b1, 8'd255, 16'sd32767, 1'b0);
        send_item(1'b1, 8'd1, 16'sd32767, 1'b0);
        send_item(1'b1, 8'd2, 16'sd32767, 1'b0);
        send_item(1'b1, 8'd3, 16'sd32767, 1'b0);
        send_item(1'b1, 8'd4, 16'sd32767, 1'b0);
        send_item(1'b1, 8'd5, 16'sd1, 1'b1);
        // replace the lowest-numbered of two equal minimums; close with an
        // empty marker carrying junk fields
        send_item(1'b1, 8'd20, 16'sd100, 1'b0);
        send_item(1'b1, 8'd21, 16'sd50, 1'b0);
        send_item(1'b1, 8'd22, 16'sd50, 1'b0);
        send_item(1'b1, 8'd23, 16'sd200, 1'b0);
        send_item(1'b1, 8'd24, 16'sd60, 1'b0);
        send_item(1'b0, 8'd99, -16'sd5, 1'b1);
        // negative weights flag the vertex even with a good sum
        send_item(1'b1, 8'd30, -16'sd32768, 1'b0);
        send_item(1'b1, 8'd31, 16'sd16384, 1'b0);
        send_item(1'b1, 8'd32, -16'sd1, 1'b1);
        // negative wins over zero sum
        send_item(1'b1, 8'd7, -16'sd1, 1'b1);
        // an empty marker with a negative weight does not flag anything
        send_item(1'b0, 8'd8, -16'sd100, 1'b0);
        send_item(1'b1, 8'd50, 16'sd1, 1'b0);
        send_item(1'b1, 8'd51, 16'sd32767, 1'b1);

        // Random: sender idles 20%, then 74%, then never
        while (items_sent < PHASE_ITEMS)
            send_vertex();
        idle_pct = 74;
        while (items_sent < 2 * PHASE_ITEMS)
            send_vertex();
        idle_pct = 0;
        while (items_sent < 3 * PHASE_ITEMS)
            send_vertex();

        // Drain: drop start, wait out every awaited result, then settle
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("skin_weight_top4_normalizer_core regression: pass");
        else
            $display("skin_weight_top4_normalizer_core regression: fail");
        $finish;
    end

endmodule
